// ----- src/etpm_pkg.sv -----
// Shared types and constants for the edge trigger period measurement block.
// No dependencies; used by etpm_track and edge_trigger_period_measure.
package etpm_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int LEVEL_W     = 10;
    localparam int PERIOD_W    = 6;
    localparam int CODE_W      = 10;
    localparam int SUM_W       = 16;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 10;

    localparam int DEF_CAPTURE_LENGTH = 64;
    localparam int DEF_SAMPLE_BITS    = 10;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(512);
    localparam logic               SLOPE_RESET = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TRIGGER_LEVEL = 1'b0,
        REG_RISING_SLOPE  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               rising;
    } etpm_cfg_t;

    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } etpm_step_t;

    typedef struct packed {
        logic [SUM_W-1:0]    code_sum;
        logic [CODE_W-1:0]   max_code;
        logic [CODE_W-1:0]   min_code;
        logic [PERIOD_W-1:0] period_samples;
    } etpm_result_t;

endpackage

// ----- src/etpm_track.sv -----
// Per-capture tracking: trigger crossings, min, max and saturating sum.
// Depends on etpm_pkg.
module etpm_track #(
    parameter int CAPTURE_LENGTH = etpm_pkg::DEF_CAPTURE_LENGTH,
    parameter int SAMPLE_BITS    = etpm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  etpm_pkg::etpm_cfg_t    cfg,
    input  etpm_pkg::etpm_step_t   step,
    output etpm_pkg::etpm_result_t result
);
    import etpm_pkg::*;

    localparam int CW    = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int IDX_W = $clog2(CAPTURE_LENGTH + 1);
    localparam int POS_W = $clog2(CAPTURE_LENGTH);
    localparam int DW    = (POS_W > PERIOD_W) ? POS_W : PERIOD_W;

    logic [CW-1:0]       prev_reg,  prev_next;
    logic [IDX_W-1:0]    idx_reg,   idx_next;
    logic [1:0]          found_reg, found_next;
    logic [POS_W-1:0]    first_reg, first_next;
    logic [PERIOD_W-1:0] dist_reg,  dist_next;
    logic [CW-1:0]       min_reg,   min_next;
    logic [CW-1:0]       max_reg,   max_next;
    logic [SUM_W-1:0]    sum_reg,   sum_next;

    logic [CW-1:0]      s;
    logic [LEVEL_W-1:0] s_ext;
    logic [LEVEL_W-1:0] prev_ext;
    logic               active;
    logic               counted;
    logic               hit;
    logic [POS_W-1:0]   dist_raw;
    logic [DW-1:0]      dist_wide;
    logic [SUM_W:0]     sum_wide;

    assign s         = step.sample[CW-1:0];
    assign s_ext     = LEVEL_W'(s);
    assign prev_ext  = LEVEL_W'(prev_reg);
    assign active    = idx_reg < IDX_W'(CAPTURE_LENGTH);
    assign counted   = idx_reg < IDX_W'(CAPTURE_LENGTH - 1);
    assign dist_raw  = idx_reg[POS_W-1:0] - first_reg;
    assign dist_wide = DW'(dist_raw);
    assign sum_wide  = {1'b0, sum_reg} + (SUM_W + 1)'(s);

    always_comb
    begin
        if (cfg.rising)
            hit = (s_ext >= cfg.level) && (prev_ext < cfg.level);
        else
            hit = (s_ext <= cfg.level) && (prev_ext > cfg.level);
    end

    always_comb
    begin
        prev_next  = prev_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        first_next = first_reg;
        dist_next  = dist_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        sum_next   = sum_reg;
        if (active)
        begin
            if (idx_reg != '0 && found_reg < 2'd2 && hit)
            begin
                if (found_reg == 2'd0)
                begin
                    first_next = idx_reg[POS_W-1:0];
                    found_next = 2'd1;
                end
                else
                begin
                    if (dist_wide > DW'(63))
                        dist_next = '1;
                    else
                        dist_next = dist_wide[PERIOD_W-1:0];
                    found_next = 2'd2;
                end
            end
            if (counted)
            begin
                if (s < min_reg)
                    min_next = s;
                if (s > max_reg)
                    max_next = s;
                sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
            end
            idx_next  = idx_reg + 1'b1;
            prev_next = s;
        end
    end

    always_comb
    begin
        result.period_samples = (found_next == 2'd2) ? dist_next : '0;
        result.min_code       = CODE_W'(min_next);
        result.max_code       = CODE_W'(max_next);
        result.code_sum       = sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            idx_reg   <= '0;
            found_reg <= '0;
            first_reg <= '0;
            dist_reg  <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
            sum_reg   <= '0;
        end
        else if (step.valid)
        begin
            if (step.last)
            begin
                prev_reg  <= '0;
                idx_reg   <= '0;
                found_reg <= '0;
                first_reg <= '0;
                dist_reg  <= '0;
                min_reg   <= '1;
                max_reg   <= '0;
                sum_reg   <= '0;
            end
            else
            begin
                prev_reg  <= prev_next;
                idx_reg   <= idx_next;
                found_reg <= found_next;
                first_reg <= first_next;
                dist_reg  <= dist_next;
                min_reg   <= min_next;
                max_reg   <= max_next;
                sum_reg   <= sum_next;
            end
        end
    end

endmodule

// ----- src/edge_trigger_period_measure.sv -----
// Top level of the edge trigger period measurement block.
// Depends on etpm_pkg and etpm_track.
//
// Takes one ADC sample per cycle while s_tready is high and returns one
// result per capture, on the transfer flagged by tlast: the distance between
// the first two trigger crossings (0 if fewer than two), and the min, max and
// saturating sum of the first CAPTURE_LENGTH-1 samples. A sample passes an
// input register and then updates the tracking state; a result is registered
// when its last sample is processed out of the input register, and it sits in
// an output register. Input is refused only when a last sample is pending
// while the previous result is still held.
module edge_trigger_period_measure #(
    parameter int CAPTURE_LENGTH = etpm_pkg::DEF_CAPTURE_LENGTH,
    parameter int SAMPLE_BITS    = etpm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [etpm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [etpm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [etpm_pkg::IN_TDATA_W-1:0]      s_tdata,  // sample[9:0], zero fill
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // period_samples[5:0], min_code[15:6], max_code[25:16], code_sum[41:26]
    output logic [etpm_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import etpm_pkg::*;

    etpm_cfg_t    cfg_reg;
    etpm_step_t   step;
    etpm_result_t result;

    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic                in_last_reg;
    logic                out_valid_reg;
    etpm_result_t        out_data_reg;
    logic                proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level  <= LEVEL_RESET;
            cfg_reg.rising <= SLOPE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_TRIGGER_LEVEL: cfg_reg.level  <= cfg_wdata[LEVEL_W-1:0];
                REG_RISING_SLOPE:  cfg_reg.rising <= cfg_wdata[0];
                default:           cfg_reg        <= cfg_reg;
            endcase
        end
    end

    assign proc     = in_valid_reg && !(in_last_reg && out_valid_reg && !m_tready);
    assign s_tready = !in_valid_reg || proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_sample_reg <= s_tdata[SAMPLE_W-1:0];
            in_last_reg   <= s_tlast;
        end
    end

    assign step.valid  = proc;
    assign step.sample = in_sample_reg;
    assign step.last   = in_last_reg;

    etpm_track #(
        .CAPTURE_LENGTH (CAPTURE_LENGTH),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .step   (step),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (proc && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc && in_last_reg)
            out_data_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_data_reg);

endmodule

// ----- src/etpm_checker.sv -----
// Port-level checks for edge_trigger_period_measure, attached by bind.
// Depends on nothing but the top level's ports.
module etpm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:6] <= m_tdata[25:16])
        else $error("min_code above max_code");

    a_sum_ge_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[41:26] >= {6'd0, m_tdata[25:16]})
        else $error("code_sum below max_code");

    a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("result without a last transfer");

endmodule

bind edge_trigger_period_measure etpm_checker u_etpm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
